// ===== hdl/pcsr_pkg.sv =====
package pcsr_pkg;

  localparam int COUNT_BITS_DEFAULT = 24;
  localparam int WIDTH_BITS = 20;
  localparam int LOCK_BITS = 16;
  localparam int CODE_BITS = 2;
  localparam int FLAG_POS = 8;
  localparam int COUNT_POS = FLAG_POS + 1;
  localparam int WIDTH_IDX_BITS = $clog2(WIDTH_BITS);
  localparam int ADDR_BITS = 3;

  localparam logic [WIDTH_BITS-1:0] WIDTH_LIMIT_RESET = 20'hFFFFF;
  localparam logic [LOCK_BITS-1:0] LOCKOUT_RESET = 16'hFFFF;

  localparam logic [CODE_BITS-1:0] CHAN_NONE = 2'd0;
  localparam logic [CODE_BITS-1:0] CHAN_A = 2'd1;
  localparam logic [CODE_BITS-1:0] CHAN_B = 2'd2;

  typedef enum logic {
    REG_WIDTH_LIMIT   = 1'b0,
    REG_LOCKOUT_TICKS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic sensor_a_level;
    logic sensor_b_level;
    logic host_clock_level;
    logic host_data_in;
  } sample_t;

  typedef struct packed {
    logic                 line_drive;
    logic                 line_value;
    logic                 capturing;
    logic [CODE_BITS-1:0] report_channel;
    logic                 link_synced;
  } report_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] width_limit;
    logic [LOCK_BITS-1:0]  lockout_ticks;
  } cfg_t;

endpackage

// ===== hdl/pcsr_regs.sv =====
module pcsr_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcsr_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output pcsr_pkg::cfg_t                  cfg
);

  logic [pcsr_pkg::WIDTH_BITS-1:0] width_limit;
  logic [pcsr_pkg::LOCK_BITS-1:0]  lockout_ticks;
  pcsr_pkg::reg_index_t            sel;

  assign sel = pcsr_pkg::reg_index_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_limit   <= pcsr_pkg::WIDTH_LIMIT_RESET;
      lockout_ticks <= pcsr_pkg::LOCKOUT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        pcsr_pkg::REG_WIDTH_LIMIT:   width_limit <= pwdata[pcsr_pkg::WIDTH_BITS-1:0];
        pcsr_pkg::REG_LOCKOUT_TICKS: lockout_ticks <= pwdata[pcsr_pkg::LOCK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      pcsr_pkg::REG_WIDTH_LIMIT:   prdata = 32'(width_limit);
      pcsr_pkg::REG_LOCKOUT_TICKS: prdata = 32'(lockout_ticks);
      default:                     prdata = '0;
    endcase
  end

  assign cfg.width_limit   = width_limit;
  assign cfg.lockout_ticks = lockout_ticks;

endmodule

// ===== hdl/pcsr_core.sv =====
module pcsr_core #(
  parameter int COUNT_BITS = pcsr_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  pcsr_pkg::sample_t sample,
  input  pcsr_pkg::cfg_t    cfg,
  output pcsr_pkg::report_t report
);

  localparam int POS_W = $clog2(pcsr_pkg::COUNT_POS + COUNT_BITS + 1);
  localparam logic [POS_W-1:0] FLAG_AT = POS_W'(pcsr_pkg::FLAG_POS);
  localparam logic [POS_W-1:0] COUNT_AT = POS_W'(pcsr_pkg::COUNT_POS);
  localparam logic [POS_W-1:0] LAST_AT = POS_W'(pcsr_pkg::COUNT_POS + COUNT_BITS);
  localparam logic [POS_W-1:0] WIDTH_END = POS_W'(pcsr_pkg::WIDTH_BITS);
  localparam logic [POS_W-1:0] CODE_END = POS_W'(pcsr_pkg::CODE_BITS);

  logic prev_sensor_a, prev_sensor_b, prev_host_clock;
  logic capture_active, capture_active_next;
  logic [pcsr_pkg::CODE_BITS-1:0] capture_source, capture_source_next;
  logic [pcsr_pkg::WIDTH_BITS-1:0] width_count, width_count_next;
  logic [pcsr_pkg::CODE_BITS-1:0] pending_code, pending_code_next;
  logic [pcsr_pkg::WIDTH_BITS-1:0] stored_width, stored_width_next;
  logic lockout_on, lockout_on_next;
  logic [pcsr_pkg::LOCK_BITS-1:0] lockout_count, lockout_count_next;
  logic sync_flag, sync_flag_next;
  logic [POS_W-1:0] bit_position, bit_position_next;
  logic drive_enable, drive_enable_next;
  logic drive_value, drive_value_next;

  logic rise_a, rise_b, rise_c, level;
  logic [pcsr_pkg::LOCK_BITS:0] lock_inc;
  logic [POS_W-1:0] k;

  assign rise_a = sample.sensor_a_level & ~prev_sensor_a;
  assign rise_b = sample.sensor_b_level & ~prev_sensor_b;
  assign rise_c = sample.host_clock_level & ~prev_host_clock;
  assign level = (capture_source == pcsr_pkg::CHAN_B) ? sample.sensor_b_level
                                                      : sample.sensor_a_level;
  assign lock_inc = {1'b0, lockout_count} + 1'b1;
  assign k = bit_position - COUNT_AT;

  always_comb begin
    capture_active_next = capture_active;
    capture_source_next = capture_source;
    width_count_next    = width_count;
    pending_code_next   = pending_code;
    stored_width_next   = stored_width;
    lockout_on_next     = lockout_on;
    lockout_count_next  = lockout_count;
    sync_flag_next      = sync_flag;
    bit_position_next   = bit_position;
    drive_enable_next   = drive_enable;
    drive_value_next    = drive_value;

    if (capture_active) begin
      if (width_count < cfg.width_limit && level) begin
        width_count_next = width_count + 1'b1;
      end else begin
        capture_active_next = 1'b0;
        pending_code_next   = capture_source;
        stored_width_next   = width_count;
        lockout_on_next     = 1'b1;
        lockout_count_next  = '0;
      end
    end else begin
      if (lockout_on) begin
        if (lock_inc >= {1'b0, cfg.lockout_ticks}) begin
          lockout_on_next    = 1'b0;
          lockout_count_next = '0;
        end else begin
          lockout_count_next = lock_inc[pcsr_pkg::LOCK_BITS-1:0];
        end
      end
      if (pending_code == pcsr_pkg::CHAN_NONE && !lockout_on && (rise_a || rise_b)) begin
        // trigger tick counts as the first sample; its level is high by definition
        capture_source_next = rise_a ? pcsr_pkg::CHAN_A : pcsr_pkg::CHAN_B;
        drive_enable_next   = 1'b1;
        drive_value_next    = 1'b0;
        sync_flag_next      = 1'b0;
        if (cfg.width_limit != '0) begin
          capture_active_next = 1'b1;
          width_count_next    = {{(pcsr_pkg::WIDTH_BITS-1){1'b0}}, 1'b1};
        end else begin
          capture_active_next = 1'b0;
          width_count_next    = '0;
          pending_code_next   = capture_source_next;
          stored_width_next   = '0;
          lockout_on_next     = 1'b1;
          lockout_count_next  = '0;
        end
      end else if (rise_c) begin
        if (!sync_flag) begin
          drive_enable_next = 1'b0;
          if (sample.host_data_in) begin
            sync_flag_next    = 1'b1;
            bit_position_next = '0;
          end
        end else begin
          drive_enable_next = 1'b1;
          if (bit_position < FLAG_AT) begin
            drive_value_next = (bit_position < CODE_END) ? pending_code[bit_position[0]]
                                                         : 1'b0;
          end else if (bit_position == FLAG_AT) begin
            drive_value_next = (pending_code != pcsr_pkg::CHAN_NONE);
            // nothing to report: drop sync
            if (pending_code == pcsr_pkg::CHAN_NONE) sync_flag_next = 1'b0;
          end else if (bit_position < LAST_AT) begin
            drive_value_next = (k < WIDTH_END)
                             ? stored_width[k[pcsr_pkg::WIDTH_IDX_BITS-1:0]] : 1'b0;
          end
          if (bit_position >= LAST_AT) begin
            // last edge: release the line and sample the host ack
            drive_enable_next = 1'b0;
            if (sample.host_data_in) pending_code_next = pcsr_pkg::CHAN_NONE;
            sync_flag_next = 1'b0;
          end else begin
            bit_position_next = bit_position + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sensor_a   <= 1'b0;
      prev_sensor_b   <= 1'b0;
      prev_host_clock <= 1'b0;
      capture_active  <= 1'b0;
      capture_source  <= pcsr_pkg::CHAN_NONE;
      width_count     <= '0;
      pending_code    <= pcsr_pkg::CHAN_NONE;
      stored_width    <= '0;
      lockout_on      <= 1'b0;
      lockout_count   <= '0;
      sync_flag       <= 1'b0;
      bit_position    <= '0;
      drive_enable    <= 1'b0;
      drive_value     <= 1'b0;
    end else if (advance) begin
      prev_sensor_a   <= sample.sensor_a_level;
      prev_sensor_b   <= sample.sensor_b_level;
      prev_host_clock <= sample.host_clock_level;
      capture_active  <= capture_active_next;
      capture_source  <= capture_source_next;
      width_count     <= width_count_next;
      pending_code    <= pending_code_next;
      stored_width    <= stored_width_next;
      lockout_on      <= lockout_on_next;
      lockout_count   <= lockout_count_next;
      sync_flag       <= sync_flag_next;
      bit_position    <= bit_position_next;
      drive_enable    <= drive_enable_next;
      drive_value     <= drive_value_next;
    end
  end

  assign report.line_drive     = drive_enable_next;
  assign report.line_value     = drive_enable_next & drive_value_next;
  assign report.capturing      = capture_active_next;
  assign report.report_channel = pending_code_next;
  assign report.link_synced    = sync_flag_next;

endmodule

// ===== hdl/pulse_capture_serial_reporter.sv =====
// Path: a sample goes through the input register and then the result register
// before its result is offered; an output stall can hold it back longer.
// Throughput: one item per cycle unless the output stalls; the state update is
// the only loop.
// Reset: synchronous rst clears all core state, empties both registers and loads
// width_limit and lockout_ticks with their all-ones defaults.
module pulse_capture_serial_reporter #(
  parameter int COUNT_BITS = pcsr_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pcsr_pkg::sample_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pcsr_pkg::report_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcsr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  pcsr_pkg::cfg_t    cfg;
  pcsr_pkg::sample_t sample;
  pcsr_pkg::report_t report;
  logic              sample_valid;
  logic              advance;

  assign advance  = sample_valid && (!out_valid || out_ready);
  assign in_ready = !sample_valid || advance;

  pcsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcsr_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (sample),
    .cfg     (cfg),
    .report  (report)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_ready) begin
      sample_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= report;
    end
  end

  a_capture_drives_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.capturing |-> out_data.line_drive && !out_data.line_value)
    else $error("capture without the line held low");

  a_no_sync_in_capture: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.capturing && out_data.link_synced))
    else $error("link synced while capturing");

  a_channel_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.report_channel == pcsr_pkg::CHAN_NONE ||
                   out_data.report_channel == pcsr_pkg::CHAN_A ||
                   out_data.report_channel == pcsr_pkg::CHAN_B))
    else $error("invalid pending channel code");

  a_stall_no_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("state advanced while result stalled");

endmodule

// ===== tb/tb_pulse_capture_serial_reporter.sv =====
module tb_pulse_capture_serial_reporter;
  import pcsr_pkg::*;

  localparam int COUNT_BITS = COUNT_BITS_DEFAULT;
  localparam int LAST_POS = COUNT_POS + COUNT_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  report_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pulse_capture_serial_reporter i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pin-level model of the reporter
  logic prv_a, prv_b, prv_hclk;
  logic cap_on;
  logic [CODE_BITS-1:0] cap_src;
  logic [WIDTH_BITS-1:0] cap_width;
  logic [CODE_BITS-1:0] pend_chan;
  logic [WIDTH_BITS-1:0] held_width;
  logic lock_on;
  logic [LOCK_BITS:0] lock_cnt;
  logic link_sync;
  logic [5:0] shift_pos;
  logic line_en, line_bit;
  logic [WIDTH_BITS-1:0] cfg_width_limit;
  logic [LOCK_BITS-1:0] cfg_lockout;

  report_t expected_reports[$];
  int mismatches = 0;
  int reports_checked = 0;
  int samples_sent = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;

  function automatic void measure_tick(input logic level);
    if (cap_width < cfg_width_limit && level) begin
      cap_width = cap_width + 1'b1;
    end else begin
      cap_on = 1'b0;
      pend_chan = cap_src;
      held_width = cap_width;
      lock_on = 1'b1;
      lock_cnt = '0;
    end
  endfunction

  function automatic report_t predict_report(input sample_t s);
    logic rise_a, rise_b, rise_hclk, was_locked, started;
    logic [5:0] pos;
    int k;
    report_t r;
    rise_a = s.sensor_a_level & ~prv_a;
    rise_b = s.sensor_b_level & ~prv_b;
    rise_hclk = s.host_clock_level & ~prv_hclk;
    started = 1'b0;
    if (cap_on) begin
      measure_tick(cap_src == CHAN_B ? s.sensor_b_level : s.sensor_a_level);
    end else begin
      was_locked = lock_on;
      if (lock_on) begin
        lock_cnt = lock_cnt + 1'b1;
        if (lock_cnt >= {1'b0, cfg_lockout}) begin
          lock_on = 1'b0;
          lock_cnt = '0;
        end
      end
      // A wins over B; triggers are dropped while locked or a report waits
      if (pend_chan == CHAN_NONE && !was_locked && (rise_a || rise_b)) begin
        cap_on = 1'b1;
        cap_src = rise_a ? CHAN_A : CHAN_B;
        cap_width = '0;
        line_en = 1'b1;
        line_bit = 1'b0;
        link_sync = 1'b0;
        measure_tick(rise_a ? s.sensor_a_level : s.sensor_b_level);
        started = 1'b1;
      end
      if (!started && rise_hclk) begin
        pos = shift_pos;
        if (!link_sync) begin
          line_en = 1'b0;
          if (s.host_data_in) begin
            link_sync = 1'b1;
            shift_pos = '0;
          end
        end else begin
          line_en = 1'b1;
          if (pos < FLAG_POS) begin
            line_bit = (pos < CODE_BITS) ? pend_chan[pos[0]] : 1'b0;
          end else if (pos == FLAG_POS) begin
            line_bit = (pend_chan != CHAN_NONE);
            if (pend_chan == CHAN_NONE) link_sync = 1'b0;
          end else if (pos < LAST_POS) begin
            k = pos - COUNT_POS;
            line_bit = (k < WIDTH_BITS) ? held_width[k] : 1'b0;
          end
          if (pos >= LAST_POS) begin
            // last edge: release the line and sample the host's ack
            line_en = 1'b0;
            if (s.host_data_in) pend_chan = CHAN_NONE;
            link_sync = 1'b0;
          end else begin
            shift_pos = pos + 1'b1;
          end
        end
      end
    end
    prv_a = s.sensor_a_level;
    prv_b = s.sensor_b_level;
    prv_hclk = s.host_clock_level;
    r.line_drive = line_en;
    r.line_value = line_en & line_bit;
    r.capturing = cap_on;
    r.report_channel = pend_chan;
    r.link_synced = link_sync;
    return r;
  endfunction

  function automatic sample_t pins(input logic a, input logic b, input logic hclk,
                                   input logic din);
    return sample_t'({a, b, hclk, din});
  endfunction

  function automatic logic rbit();
    return $urandom_range(1) != 0;
  endfunction

  function automatic logic noise(input bit noisy);
    return noisy && $urandom_range(9) == 0;
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_reports.push_back(predict_report(s));
    samples_sent++;
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WIDTH_LIMIT) cfg_width_limit = value[WIDTH_BITS-1:0];
    else cfg_lockout = value[LOCK_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic host_edge(input logic din, input bit noisy);
    send_sample(pins(noise(noisy), noise(noisy), 1'b0, rbit()));
    send_sample(pins(noise(noisy), noise(noisy), 1'b1, din));
  endtask

  // Sync if needed, then clock bits out until the link drops or the edge budget runs out
  task automatic shift_report(input logic ack, input int max_edges, input bit noisy);
    int edges;
    edges = 0;
    if (!link_sync) begin
      host_edge(1'b1, noisy);
      edges++;
    end
    while (link_sync && edges < max_edges) begin
      host_edge(shift_pos == LAST_POS ? ack : rbit(), noisy);
      edges++;
    end
  endtask

  task automatic run_report_cycle(input bit complete);
    int src, hold, gap;
    logic sa, sb;
    src = $urandom_range(2);
    sa = (src != 1);
    sb = (src != 0);
    hold = ($urandom_range(7) == 0) ? $urandom_range(30, 200) : $urandom_range(0, 12);
    gap = $urandom_range(0, (cfg_lockout < 40) ? cfg_lockout + 2 : 40);
    send_sample(pins(1'b0, 1'b0, 1'b0, rbit()));
    send_sample(pins(sa, sb, 1'b0, rbit()));
    // hold the source pin high; everything else may wander
    repeat (hold) send_sample(pins(sa | rbit(), sb | rbit(), rbit(), rbit()));
    send_sample(pins(1'b0, 1'b0, 1'b0, rbit()));
    repeat (gap) send_sample(pins(noise(1'b1), noise(1'b1), 1'b0, rbit()));
    if (complete) shift_report($urandom_range(99) < 85, 40, 1'b1);
    else shift_report(rbit(), $urandom_range(0, 20), 1'b1);
  endtask

  task automatic test_register_extremes();
    wait_for_reports();
    write_register(REG_WIDTH_LIMIT, 32'd0);
    write_register(REG_LOCKOUT_TICKS, 32'd0);
    send_sample(pins(1'b0, 1'b0, 1'b0, 1'b0));
    // both sensors rise together: A wins, zero limit stores a width of 0 at once
    send_sample(pins(1'b1, 1'b1, 1'b0, 1'b0));
    send_sample(pins(1'b0, 1'b0, 1'b0, 1'b0));
    shift_report(1'b1, 40, 1'b0);
    wait_for_reports();
    write_register(REG_WIDTH_LIMIT, 32'(WIDTH_LIMIT_RESET));
    write_register(REG_LOCKOUT_TICKS, 32'(LOCKOUT_RESET));
    send_sample(pins(1'b0, 1'b0, 1'b0, 1'b1));
    send_sample(pins(1'b0, 1'b1, 1'b0, 1'b1));
    send_sample(pins(1'b0, 1'b1, 1'b0, 1'b0));
    send_sample(pins(1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(pins(1'b1, 1'b0, 1'b0, 1'b0));
    shift_report(1'b1, 40, 1'b0);
    // report gone but the long lockout still blocks triggers
    send_sample(pins(1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(pins(1'b1, 1'b0, 1'b0, 1'b0));
    wait_for_reports();
    write_register(REG_LOCKOUT_TICKS, 32'd1);
  endtask

  task automatic test_capture_rules();
    wait_for_reports();
    write_register(REG_WIDTH_LIMIT, 32'd3);
    write_register(REG_LOCKOUT_TICKS, 32'd2);
    send_sample(pins(1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(pins(1'b1, 1'b0, 1'b0, 1'b0));
    send_sample(pins(1'b1, 1'b0, 1'b0, 1'b0));
    // sensor B and host clock edges are ignored mid-capture
    send_sample(pins(1'b1, 1'b1, 1'b1, 1'b0));
    send_sample(pins(1'b1, 1'b1, 1'b0, 1'b0));
    send_sample(pins(1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(pins(1'b0, 1'b1, 1'b0, 1'b0));
    // unsynced edge with data low only releases the line
    send_sample(pins(1'b0, 1'b0, 1'b1, 1'b0));
    send_sample(pins(1'b0, 1'b0, 1'b0, 1'b0));
    send_sample(pins(1'b0, 1'b0, 1'b1, 1'b1));
    send_sample(pins(1'b0, 1'b0, 1'b0, 1'b1));
    send_sample(pins(1'b0, 1'b0, 1'b1, 1'b1));
    shift_report(1'b0, 40, 1'b0);
    shift_report(1'b1, 40, 1'b0);
    // nothing pending: the flag goes out as 0 and the link drops
    shift_report(1'b1, 12, 1'b0);
  endtask

  task automatic test_random_traffic(input int count);
    int stop_at, kind;
    repeat (2) begin
      wait_for_reports();
      case ($urandom_range(3))
        0: write_register(REG_WIDTH_LIMIT, 32'd1);
        1: write_register(REG_WIDTH_LIMIT, $urandom_range(2, 12));
        2: write_register(REG_WIDTH_LIMIT, $urandom_range(13, 250));
        default: write_register(REG_WIDTH_LIMIT, $urandom_range(1, 1048575));
      endcase
      case ($urandom_range(2))
        0: write_register(REG_LOCKOUT_TICKS, 32'd1);
        1: write_register(REG_LOCKOUT_TICKS, $urandom_range(2, 40));
        default: write_register(REG_LOCKOUT_TICKS, $urandom_range(41, 120));
      endcase
      stop_at = samples_sent + count / 2;
      while (samples_sent < stop_at) begin
        kind = $urandom_range(99);
        if (kind < 60) begin
          run_report_cycle(1'b1);
        end else if (kind < 72) begin
          shift_report($urandom_range(99) < 85, 40, 1'b0);
        end else if (kind < 88) begin
          run_report_cycle(1'b0);
        end else begin
          repeat ($urandom_range(5, 30)) send_sample(pins(rbit(), rbit(), rbit(), rbit()));
        end
      end
    end
  endtask

  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && out_valid && out_ready) begin
      reports_checked++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("report %0d arrived with nothing expected: %p", reports_checked, out_data);
        end
      end else begin
        want = expected_reports.pop_front();
        if (out_data.line_drive !== want.line_drive || out_data.line_value !== want.line_value ||
            out_data.capturing !== want.capturing ||
            out_data.report_channel !== want.report_channel ||
            out_data.link_synced !== want.link_synced) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("report %0d: expected drive %b value %b capturing %b channel %0d synced %b",
                     reports_checked, want.line_drive, want.line_value, want.capturing,
                     want.report_channel, want.link_synced);
            $display("report %0d:      got drive %b value %b capturing %b channel %0d synced %b",
                     reports_checked, out_data.line_drive, out_data.line_value,
                     out_data.capturing, out_data.report_channel, out_data.link_synced);
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    #3_000_000;
    $display("tb_pulse_capture_serial_reporter NOT OK");
    $finish;
  end

  initial begin
    prv_a = 1'b0;
    prv_b = 1'b0;
    prv_hclk = 1'b0;
    cap_on = 1'b0;
    cap_src = CHAN_NONE;
    cap_width = '0;
    pend_chan = CHAN_NONE;
    held_width = '0;
    lock_on = 1'b0;
    lock_cnt = '0;
    link_sync = 1'b0;
    shift_pos = '0;
    line_en = 1'b0;
    line_bit = 1'b0;
    cfg_width_limit = WIDTH_LIMIT_RESET;
    cfg_lockout = LOCKOUT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_gap_pct = 22;
    rx_stall_pct = 75;
    test_register_extremes();
    test_capture_rules();
    test_random_traffic(250);
    tx_gap_pct = 75;
    rx_stall_pct = 22;
    test_random_traffic(250);
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    test_random_traffic(250);

    wait_for_reports();
    if (mismatches == 0) $display("tb_pulse_capture_serial_reporter OK");
    else $display("tb_pulse_capture_serial_reporter NOT OK");
    $finish;
  end

endmodule
